// ===== rtl/aap_pkg.sv =====
// ----------------------------------------------------------------------------
// aap_pkg
// Shared types and constants for the adaptive average pooling block.
// ----------------------------------------------------------------------------
package aap_pkg;

    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_W     = 7;   // configuration register width
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 6;   // out_row / out_col width

    localparam logic [CFG_W-1:0] RST_IN_HEIGHT  = 7'd8;
    localparam logic [CFG_W-1:0] RST_IN_WIDTH   = 7'd8;
    localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 7'd1;
    localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT  = 2'd0,
        CFG_IN_WIDTH   = 2'd1,
        CFG_OUT_HEIGHT = 2'd2,
        CFG_OUT_WIDTH  = 2'd3
    } cfg_idx_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SIZE_ERR = 1'b1;

    typedef enum logic [4:0] {
        ST_CFG,
        ST_DH_GO,
        ST_DH_WT,
        ST_DW_GO,
        ST_DW_WT,
        ST_PH,
        ST_AREA,
        ST_IDLE,
        ST_CR_GO,
        ST_CR_WT,
        ST_CC_GO,
        ST_CC_WT,
        ST_SUM,
        ST_TAIL,
        ST_MD_GO,
        ST_MD_WT,
        ST_EMIT
    } aap_state_t;

endpackage

// ===== rtl/aap_if.sv =====
// ----------------------------------------------------------------------------
// aap_if
// Stream interfaces: pixel requests in, pooled result requests out.
// ----------------------------------------------------------------------------
interface aap_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface aap_res_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] mean;
    logic [5:0]                   out_row;
    logic [5:0]                   out_col;
    logic                         last;
    logic                         status;

    modport source (output valid, output mean, output out_row, output out_col,
                    output last, output status, input ready);
    modport sink   (input valid, input mean, input out_row, input out_col,
                    input last, input status, output ready);
endinterface

// ===== rtl/adaptive_average_pool_2d.sv =====
// ----------------------------------------------------------------------------
// adaptive_average_pool_2d
// Adaptive 2-D average pooling over one raster-order plane of pixels.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    accepted when
//  pixels    in   pixel (signed Q8.8)                        valid & ready
//  results   out  mean, out_row, out_col, last, status       valid & ready
//  cfg       in   cfg_index, cfg_data (no read-back)         cfg_we
//
//  A pixel short of the first window corner is taken back to back.
//  Past the corner, a row-phase divide runs, then a column-phase divide if the
//  row phase fits; a pixel that closes a window also reads ph*pw store
//  entries and runs the mean divide. An error pixel goes straight to emit.
//  After reset and every register write, setup runs with ready low (its
//  step divides skipped on a size error). Result stalls hold the block in its
//  emit state; one finished result waits in the output register.
// ----------------------------------------------------------------------------
module adaptive_average_pool_2d
    import aap_pkg::*;
#(
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    aap_pix_if.sink              pixels,
    aap_res_if.source            results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int MAXD  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int DIMW  = $clog2(MAXD + 1);
    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = PIXEL_BITS + AW + 1;
    localparam int DW    = (AW + 1 > DIMW) ? AW + 1 : DIMW;

    // configuration registers
    logic [CFG_W-1:0] in_h_reg, in_w_reg, out_h_reg, out_w_reg;

    // derived geometry
    logic [DIMW-1:0] hc, wc, ohc, owc;
    logic            err_reg;
    logic [DIMW-1:0] sh_reg, sw_reg, ph_reg, pw_reg;
    logic [DW-1:0]   area_reg;

    // stream position
    logic [DIMW-1:0] row_reg, col_reg;
    logic [DIMW-1:0] rr, cc;
    logic            win_hit;
    logic [DIMW-1:0] cur_r_reg, cur_c_reg, dr_reg, dc_reg;
    logic            final_reg;

    // window sum
    logic [DIMW-1:0]         i_reg, j_reg;
    logic                    rd_en_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0]        acc_mag;

    // plane store
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         wr_addr, rd_addr;

    // divider
    logic             div_start, div_done;
    logic [SUM_W-1:0] div_num, div_quo;
    logic [DW-1:0]    div_den, div_rem;

    // result register
    logic                  res_valid_reg;
    logic [PIXEL_BITS-1:0] mean_reg;
    logic [IDX_W-1:0]      orow_reg, ocol_reg;
    logic                  res_last_reg, res_status_reg;

    aap_state_t state_reg, state_next;

    logic accept;
    logic emit_go;

    function automatic logic [DIMW-1:0] clamp_dim(logic [CFG_W-1:0] v, int mx);
        logic [DIMW-1:0] r;
        if (v == '0)
            r = DIMW'(1);
        else if (int'(v) > mx)
            r = DIMW'(mx);
        else
            r = DIMW'(v);
        return r;
    endfunction

    assign hc  = clamp_dim(in_h_reg, MAX_HEIGHT);
    assign wc  = clamp_dim(in_w_reg, MAX_WIDTH);
    assign ohc = clamp_dim(out_h_reg, MAX_HEIGHT);
    assign owc = clamp_dim(out_w_reg, MAX_WIDTH);

    assign accept  = pixels.valid && pixels.ready;
    assign emit_go = !res_valid_reg || results.ready;

    // stale counters (beyond the plane) restart at the origin
    always_comb
    begin
        if (row_reg >= hc || col_reg >= wc)
        begin
            rr = '0;
            cc = '0;
        end
        else
        begin
            rr = row_reg;
            cc = col_reg;
        end
    end

    // this pixel is at or past the first bottom-right corner in both axes
    assign win_hit = ({1'b0, rr} + 1'b1 >= {1'b0, ph_reg})
                  && ({1'b0, cc} + 1'b1 >= {1'b0, pw_reg});

    assign wr_addr = AW'(rr) * AW'(MAX_WIDTH) + AW'(cc);
    assign rd_addr = AW'(i_reg) * AW'(MAX_WIDTH) + AW'(j_reg);

    assign acc_mag = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_h_reg  <= RST_IN_HEIGHT;
            in_w_reg  <= RST_IN_WIDTH;
            out_h_reg <= RST_OUT_HEIGHT;
            out_w_reg <= RST_OUT_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IN_HEIGHT:  in_h_reg  <= cfg_data;
                CFG_IN_WIDTH:   in_w_reg  <= cfg_data;
                CFG_OUT_HEIGHT: out_h_reg <= cfg_data;
                CFG_OUT_WIDTH:  out_w_reg <= cfg_data;
                default:        in_h_reg  <= in_h_reg;
            endcase
        end
    end

    // ---------------- plane store ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
            mem[wr_addr] <= pixels.pixel;
        rd_data_reg <= mem[rd_addr];
    end

    // ---------------- shared divider ----------------
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_DH_GO:
            begin
                div_start = 1'b1;
                div_num   = SUM_W'(hc);
                div_den   = DW'(ohc);
            end
            ST_DW_GO:
            begin
                div_start = 1'b1;
                div_num   = SUM_W'(wc);
                div_den   = DW'(owc);
            end
            ST_CR_GO:
            begin
                div_start = 1'b1;
                div_num   = SUM_W'(dr_reg);
                div_den   = DW'(sh_reg);
            end
            ST_CC_GO:
            begin
                div_start = 1'b1;
                div_num   = SUM_W'(dc_reg);
                div_den   = DW'(sw_reg);
            end
            ST_MD_GO:
            begin
                div_start = 1'b1;
                div_num   = acc_mag;
                div_den   = area_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    aap_div #(
        .NW(SUM_W),
        .DW(DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CFG;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CFG:   state_next = (ohc > hc || owc > wc) ? ST_IDLE : ST_DH_GO;
            ST_DH_GO: state_next = ST_DH_WT;
            ST_DH_WT: state_next = div_done ? ST_DW_GO : ST_DH_WT;
            ST_DW_GO: state_next = ST_DW_WT;
            ST_DW_WT: state_next = div_done ? ST_PH : ST_DW_WT;
            ST_PH:    state_next = ST_AREA;
            ST_AREA:  state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (err_reg)
                        state_next = ST_EMIT;
                    else if (win_hit)
                        state_next = ST_CR_GO;
                end
            end
            ST_CR_GO: state_next = ST_CR_WT;
            ST_CR_WT:
            begin
                if (div_done)
                begin
                    if (div_rem != '0 || div_quo >= SUM_W'(ohc))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CC_GO;
                end
            end
            ST_CC_GO: state_next = ST_CC_WT;
            ST_CC_WT:
            begin
                if (div_done)
                begin
                    if (div_rem != '0 || div_quo >= SUM_W'(owc))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (i_reg == cur_r_reg && j_reg == cur_c_reg)
                    state_next = ST_TAIL;
            end
            ST_TAIL:  state_next = ST_MD_GO;
            ST_MD_GO: state_next = ST_MD_WT;
            ST_MD_WT: state_next = div_done ? ST_EMIT : ST_MD_WT;
            ST_EMIT:  state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_CFG;
        endcase
        // a register write restarts setup and the plane
        if (cfg_we)
            state_next = ST_CFG;
    end

    assign pixels.ready = (state_reg == ST_IDLE) && !cfg_we;

    // ---------------- position counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cfg_we)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (cc + 1'b1 < wc)
            begin
                col_reg <= cc + 1'b1;
                row_reg <= rr;
            end
            else
            begin
                col_reg <= '0;
                row_reg <= (rr + 1'b1 < hc) ? rr + 1'b1 : '0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= 1'b0;
            rd_en_reg <= 1'b0;
        end
        else
        begin
            rd_en_reg <= (state_reg == ST_SUM);
            if (state_reg == ST_CFG)
                err_reg <= (ohc > hc) || (owc > wc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en_reg)
            acc_reg <= acc_reg + {{(SUM_W-PIXEL_BITS){rd_data_reg[PIXEL_BITS-1]}},
                                  rd_data_reg};
        case (state_reg)
            ST_DH_WT:
                if (div_done)
                    sh_reg <= div_quo[DIMW-1:0];
            ST_DW_WT:
                if (div_done)
                    sw_reg <= div_quo[DIMW-1:0];
            ST_PH:
            begin
                ph_reg <= hc - DIMW'((ohc - 1'b1) * sh_reg);
                pw_reg <= wc - DIMW'((owc - 1'b1) * sw_reg);
            end
            ST_AREA:
                area_reg <= DW'(ph_reg) * DW'(pw_reg);
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_r_reg <= rr;
                    cur_c_reg <= cc;
                    final_reg <= (rr == hc - 1'b1) && (cc == wc - 1'b1);
                    dr_reg    <= rr + 1'b1 - ph_reg;
                    dc_reg    <= cc + 1'b1 - pw_reg;
                    mean_reg  <= '0;
                    orow_reg  <= '0;
                    ocol_reg  <= '0;
                end
            end
            ST_CR_WT:
                if (div_done)
                    orow_reg <= div_quo[IDX_W-1:0];
            ST_CC_WT:
            begin
                if (div_done)
                begin
                    ocol_reg <= div_quo[IDX_W-1:0];
                    i_reg    <= dr_reg;
                    j_reg    <= dc_reg;
                    acc_reg  <= '0;
                end
            end
            ST_SUM:
            begin
                if (j_reg == cur_c_reg)
                begin
                    j_reg <= dc_reg;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_MD_WT:
            begin
                if (div_done)
                begin
                    if (acc_reg[SUM_W-1])
                        mean_reg <= PIXEL_BITS'(~div_quo + 1'b1);
                    else
                        mean_reg <= div_quo[PIXEL_BITS-1:0];
                end
            end
            default:
            begin
                mean_reg <= mean_reg;
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == ST_EMIT && emit_go)
            res_valid_reg <= 1'b1;
        else if (results.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            results.mean    <= mean_reg;
            results.out_row <= orow_reg;
            results.out_col <= ocol_reg;
            res_last_reg    <= final_reg;
            res_status_reg  <= err_reg ? STATUS_SIZE_ERR : STATUS_OK;
        end
    end

    assign results.valid  = res_valid_reg;
    assign results.last   = res_last_reg;
    assign results.status = res_status_reg;

    // ---------------- checks ----------------
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DH_WT || state_reg == ST_DW_WT ||
                      state_reg == ST_CR_WT || state_reg == ST_CC_WT ||
                      state_reg == ST_MD_WT))
        else $error("divider finished outside a wait state");

    a_err_goes_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg) |=> state_reg == ST_EMIT)
        else $error("error pixel did not produce a result");

    a_sum_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> !err_reg)
        else $error("window sum while sizes are in error");

    a_sum_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> (i_reg <= cur_r_reg && j_reg <= cur_c_reg))
        else $error("window read beyond current pixel");

endmodule

// ===== rtl/aap_div.sv =====
// ----------------------------------------------------------------------------
// aap_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aap_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW:0]    rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DW-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    shifted;
    logic           fits;

    assign shifted = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[DW-1:0];

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for adaptive_average_pool_2d: a pixel driver, a result
// monitor and a window-mean predictor, run over many plane and pool sizes.
// ----------------------------------------------------------------------------
module testbench
    import aap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 64;
    localparam int ITEM_GOAL    = 1050;
    localparam int DRAIN_CYCLES = 400;     // covers a divider run with margin
    localparam int STALL_LIMIT  = 20000;   // cycles with no handshake at all

    typedef struct packed {
        logic signed [15:0] mean;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
        logic               last;
        logic               status;
    } pool_res_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    aap_pix_if pix_if ();
    aap_res_if res_if ();

    adaptive_average_pool_2d i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Pixels waiting to be driven, and window results waiting to come back.
    logic signed [15:0] pixel_fifo[$];
    pool_res_t          window_fifo[$];

    int pixels_sent;      // requests pushed into the pixel FIFO
    int pixels_taken;
    int results_seen;
    int error_results;
    int mismatches;
    int idle_cycles;
    int src_idle_pct;
    int rcv_idle_pct;

    // Predictor state: its own copy of the registers, plane and raster position.
    logic [CFG_W-1:0]   reg_in_h, reg_in_w, reg_out_h, reg_out_w;
    logic signed [15:0] plane[MAX_DIM][MAX_DIM];
    int                 row_pos, col_pos;

    // A zero register acts as 1, anything above 64 as 64.
    function automatic int dim_of(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Stores the pixel, advances the raster and tells whether it closes a
    // window (or is an error pixel), filling in the result it should give.
    function automatic bit pool_predict(input logic signed [15:0] px,
                                        output pool_res_t res);
        int h, w, oh, ow, rr, cc, sh, sw, ph, pw, dr, dc;
        bit at_end;
        longint acc;
        h  = dim_of(reg_in_h);
        w  = dim_of(reg_in_w);
        oh = dim_of(reg_out_h);
        ow = dim_of(reg_out_w);
        rr = row_pos;
        cc = col_pos;
        res = '0;
        if (rr >= h || cc >= w) begin
            rr = 0;
            cc = 0;
        end
        plane[rr][cc] = px;
        at_end = (rr == h - 1) && (cc == w - 1);
        if (cc + 1 < w) begin
            col_pos = cc + 1;
            row_pos = rr;
        end
        else begin
            col_pos = 0;
            row_pos = (rr + 1 < h) ? rr + 1 : 0;
        end
        if (oh > h || ow > w) begin
            res.last   = at_end;
            res.status = STATUS_SIZE_ERR;
            return 1'b1;
        end
        sh = h / oh;
        sw = w / ow;
        ph = h - (oh - 1) * sh;
        pw = w - (ow - 1) * sw;
        if (rr + 1 < ph || cc + 1 < pw) return 1'b0;
        dr = rr + 1 - ph;
        dc = cc + 1 - pw;
        if (dr % sh != 0 || dc % sw != 0) return 1'b0;
        if (dr / sh >= oh || dc / sw >= ow) return 1'b0;
        acc = 0;
        for (int i = dr; i <= rr; i++)
            for (int j = dc; j <= cc; j++)
                acc += longint'(plane[i][j]);
        // longint division truncates toward zero, as the block must
        res.mean    = 16'(acc / longint'(ph * pw));
        res.out_row = 6'(dr / sh);
        res.out_col = 6'(dc / sw);
        res.last    = at_end;
        res.status  = STATUS_OK;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel driver: a new request goes out only once the old one is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pix_if.valid <= 1'b0;
            pix_if.pixel <= '0;
        end
        else if (!pix_if.valid || pix_if.ready) begin
            if (pixel_fifo.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                pix_if.valid <= 1'b1;
                pix_if.pixel <= pixel_fifo.pop_front();
            end
            else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Result back-pressure.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every taken pixel, checks every taken result,
    // and runs the no-progress watchdog.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        pool_res_t want;
        pool_res_t got;
        bit        progress;
        progress = 1'b0;
        if (rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                progress = 1'b1;
                pixels_taken++;
                if (pool_predict(pix_if.pixel, want))
                    window_fifo.push_back(want);
            end
            if (res_if.valid && res_if.ready) begin
                progress = 1'b1;
                results_seen++;
                got = '{res_if.mean, res_if.out_row, res_if.out_col,
                        res_if.last, res_if.status};
                if (got.status == STATUS_SIZE_ERR)
                    error_results++;
                if (window_fifo.size() == 0) begin
                    $error("unexpected result request: mean %0d row %0d col %0d",
                           got.mean, got.out_row, got.out_col);
                    mismatches++;
                end
                else begin
                    want = window_fifo.pop_front();
                    if (got.mean !== want.mean) begin
                        $error("mean: expected %0d, got %0d", want.mean, got.mean);
                        mismatches++;
                    end
                    if (got.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d",
                               want.out_row, got.out_row);
                        mismatches++;
                    end
                    if (got.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d",
                               want.out_col, got.out_col);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0b, got %0b",
                               want.status, got.status);
                        mismatches++;
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // One register write; the model takes it as soon as it is driven, before the block registers it.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_IN_HEIGHT:  reg_in_h  = val;
            CFG_IN_WIDTH:   reg_in_w  = val;
            CFG_OUT_HEIGHT: reg_out_h = val;
            default:        reg_out_w = val;
        endcase
        row_pos = 0;
        col_pos = 0;
    endtask

    // Idle schedule follows how far the stimulus has got.
    task automatic set_idling();
        if (pixels_sent < ITEM_GOAL / 3) begin
            src_idle_pct = 27;
            rcv_idle_pct = 82;
        end
        else if (pixels_sent < 2 * ITEM_GOAL / 3) begin
            src_idle_pct = 82;
            rcv_idle_pct = 27;
        end
        else begin
            src_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Waits for every pixel to be taken and every result to return, then
    // lets the block finish any pixel that closes no window.
    task automatic wait_quiet();
        do @(negedge clk); while (pixel_fifo.size() > 0 || pix_if.valid);
        while (window_fifo.size() > 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Program all four registers (in a shuffled order) and push pixels.
    task automatic run_phase(input logic [CFG_W-1:0] ih, input logic [CFG_W-1:0] iw,
                             input logic [CFG_W-1:0] oh, input logic [CFG_W-1:0] ow,
                             input int npix, input bit random_px,
                             input logic signed [15:0] fixed_px);
        int order[4];
        int k, tmp;
        order = '{0, 1, 2, 3};
        for (k = 3; k > 0; k--) begin
            tmp = $urandom_range(k);
            {order[k], order[tmp]} = {order[tmp], order[k]};
        end
        for (k = 0; k < 4; k++)
            case (order[k])
                0:       write_reg(CFG_IN_HEIGHT, ih);
                1:       write_reg(CFG_IN_WIDTH, iw);
                2:       write_reg(CFG_OUT_HEIGHT, oh);
                default: write_reg(CFG_OUT_WIDTH, ow);
            endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        set_idling();
        for (k = 0; k < npix; k++)
            pixel_fifo.push_back(random_px ? rand_pixel() : fixed_px);
        pixels_sent += npix;
        wait_quiet();
    endtask

    initial begin
        int h, w, oh, ow, kind, npix;
        logic [CFG_W-1:0] rh, rw, roh, row_r;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_IN_HEIGHT;
        cfg_data     = '0;
        src_idle_pct = 27;
        rcv_idle_pct = 82;
        reg_in_h     = RST_IN_HEIGHT;
        reg_in_w     = RST_IN_WIDTH;
        reg_out_h    = RST_OUT_HEIGHT;
        reg_out_w    = RST_OUT_WIDTH;
        row_pos      = 0;
        col_pos      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extreme pixels through a 1x1 plane, a saturated 2x2 mean,
        // a negative mean of exactly minus one, overlapping windows, and
        // every pixel an error when the pooled size beats the input.
        run_phase(7'd1, 7'd1, 7'd1, 7'd1, 1, 1'b0, 16'sh8000);
        run_phase(7'd1, 7'd1, 7'd1, 7'd1, 1, 1'b0, 16'sh7fff);
        run_phase(7'd2, 7'd2, 7'd1, 7'd1, 4, 1'b0, 16'sh8000);
        run_phase(7'd1, 7'd3, 7'd1, 7'd1, 3, 1'b0, 16'shffff);
        run_phase(7'd3, 7'd2, 7'd2, 7'd2, 6, 1'b1, '0);
        run_phase(7'd1, 7'd2, 7'd2, 7'd2, 4, 1'b1, '0);
        run_phase(7'd0, 7'd0, 7'd0, 7'd0, 2, 1'b1, '0);

        // Random plane and pool shapes.
        while (pixels_sent < ITEM_GOAL) begin
            kind = $urandom_range(99);
            h  = $urandom_range(1, 10);
            w  = $urandom_range(1, 10);
            oh = $urandom_range(1, h);
            ow = $urandom_range(1, w);
            rh = 7'(h);
            rw = 7'(w);
            roh = 7'(oh);
            row_r = 7'(ow);
            if (kind < 7) begin
                // pooled size larger than the input
                if ($urandom_range(1)) roh = 7'(h + $urandom_range(1, 3));
                else                   row_r = 7'(w + $urandom_range(1, 3));
            end
            else if (kind < 15) begin
                // out-of-range encodings: zero or above the maximum
                rh  = $urandom_range(1) ? 7'd0 : 7'($urandom_range(65, 127));
                roh = $urandom_range(1) ? 7'd0 : 7'($urandom_range(65, 127));
                row_r = $urandom_range(3) == 0 ? 7'd127 : row_r;
            end
            else if (kind < 20) begin
                // a full-size dimension, the other kept narrow
                if ($urandom_range(1)) begin
                    rh = $urandom_range(1) ? 7'd64 : 7'd127;
                    rw = 7'($urandom_range(1, 2));
                    roh = $urandom_range(1) ? 7'd64 : 7'($urandom_range(1, 64));
                    row_r = 7'd1;
                end
                else begin
                    rw = $urandom_range(1) ? 7'd64 : 7'd127;
                    rh = 7'($urandom_range(1, 2));
                    row_r = $urandom_range(1) ? 7'd64 : 7'($urandom_range(1, 64));
                    roh = 7'd1;
                end
            end
            npix = dim_of(rh) * dim_of(rw) * $urandom_range(1, 3);
            if ($urandom_range(99) < 15)
                npix += $urandom_range(1, dim_of(rh) * dim_of(rw));
            // keep the total close to the pixel budget
            if (npix > ITEM_GOAL - pixels_sent)
                npix = ITEM_GOAL - pixels_sent;
            run_phase(rh, rw, roh, row_r, npix, 1'b1, '0);
        end

        $display("covered %0d pixel requests, %0d result requests (%0d size errors)",
                 pixels_taken, results_seen, error_results);
        $display("plane shapes up to 64 rows or columns, under three idle schedules");
        if (mismatches == 0 && window_fifo.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
